/* hw/rtl/rghc_pkg.sv */
package rghc_pkg;

  // Default sizes
  localparam int unsigned MAX_COLUMNS_DEF  = 16;
  localparam int unsigned CHANNELS_DEF     = 64;
  localparam int unsigned COLUMN_WORDS_DEF = 128;

  // Fixed field widths
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned DEC_W   = 14;
  localparam int unsigned GRAY_W  = 12;
  localparam int unsigned CHAN_W  = 6;
  localparam int unsigned COL_W   = 6;
  localparam int unsigned GAP_W   = 14;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned SCA_W   = 5;
  localparam int unsigned CFG_W   = 14;
  localparam int unsigned CFG_IDX_W = 2;

  // Hit flag position in a decoded word
  localparam int unsigned HIT_BIT = 12;

  typedef enum logic [1:0] {
    FUNC_WORD  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_CH = 2'd0,
    REG_LAST_CH  = 2'd1,
    REG_GAP      = 2'd2,
    REG_SPARE    = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RD    = 4'b0010,
    S_WALK  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_e;

  // What one readout word does to the stores
  typedef struct packed {
    logic             charge_hit;
    logic [COL_W-1:0] bmp_col;
    logic [CHAN_W-1:0] bit_idx;
    logic             close_a;
    logic [COL_W-1:0] col_a;
    logic             clean_a;
    logic             close_b;
  } op_t;

  // Gray to binary on the low 12 bits, raw bits 12 and 13 kept
  function automatic logic [DEC_W-1:0] gray_decode(input logic [RAW_W-1:0] raw);
    logic [GRAY_W-1:0] g;
    logic [GRAY_W-1:0] b;
    g = raw[GRAY_W-1:0];
    for (int i = 0; i < GRAY_W; i++) begin
      b[i] = ^(g >> i);
    end
    return {raw[DEC_W-1:GRAY_W], b};
  endfunction

endpackage

/* hw/rtl/rghc_ram.sv */
module rghc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/rghc_pos.sv */
module rghc_pos #(
  parameter int unsigned MaxColumns  = 16,
  parameter int unsigned Channels    = 64,
  parameter int unsigned ColumnWords = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        word_acc_i,
  input  logic [rghc_pkg::RAW_W-1:0]  raw_word_i,
  input  logic                        start_req_i,
  input  logic [rghc_pkg::SCA_W-1:0]  sca_count_i,
  input  logic [rghc_pkg::GAP_W-1:0]  gap_i,
  output logic [rghc_pkg::DEC_W-1:0]  dec_o,
  output rghc_pkg::op_t               op_o
);
  import rghc_pkg::*;

  localparam int unsigned KW = $clog2(MaxColumns + 2);
  localparam int unsigned WW = (ColumnWords > 1) ? $clog2(ColumnWords) : 1;

  // position as column index and word index
  logic [KW-1:0]    k_q, k_d, k_cur;
  logic [WW-1:0]    w_q, w_d, w_cur;
  logic [DEC_W-1:0] prev_q, prev_d;

  logic [6:0] n_c;
  logic [8:0] w_ext;
  logic       charge, bcid;
  logic [6:0] col_chg;
  logic [8:0] col_bcid;
  logic [8:0] bit_full;
  logic signed [DEC_W+1:0] diff;

  assign dec_o = gray_decode(raw_word_i);

  always_comb begin
    n_c = ({2'b00, sca_count_i} > 7'(MaxColumns)) ? 7'(MaxColumns) : {2'b00, sca_count_i};
    k_cur = start_req_i ? '0 : k_q;
    w_cur = start_req_i ? '0 : w_q;
    w_ext = 9'(w_cur);

    charge = 7'(k_cur) < n_c;
    bcid   = (7'(k_cur) == n_c) && (w_ext < {2'b00, n_c});

    col_chg  = n_c - 7'd1 - 7'(k_cur);
    col_bcid = {2'b00, n_c} - 9'd1 - w_ext;
    bit_full = 9'(Channels - 1) - w_ext;

    // signed BCID step against the gap
    diff = $signed({2'b00, prev_q}) - $signed({2'b00, dec_o});

    op_o.charge_hit = charge && (w_ext < 9'(Channels)) && dec_o[HIT_BIT];
    op_o.bmp_col    = col_chg[COL_W-1:0];
    op_o.bit_idx    = bit_full[CHAN_W-1:0];
    op_o.close_a    = bcid && (w_cur != '0);
    op_o.col_a      = col_bcid[COL_W-1:0] + COL_W'(1);
    op_o.clean_a    = diff >= $signed({2'b00, gap_i});
    op_o.close_b    = bcid && (col_bcid == 9'd0);
  end

  // position advance, stops past the last BCID word
  always_comb begin
    k_d    = k_q;
    w_d    = w_q;
    prev_d = prev_q;
    if (word_acc_i) begin
      k_d    = k_cur;
      w_d    = w_cur;
      prev_d = start_req_i ? '0 : prev_q;
      if (charge || bcid) begin
        if (w_cur == WW'(ColumnWords - 1)) begin
          w_d = '0;
          k_d = k_cur + KW'(1);
        end else begin
          w_d = w_cur + WW'(1);
        end
      end
      if (bcid) begin
        prev_d = dec_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      w_q    <= '0;
      prev_q <= '0;
    end else begin
      k_q    <= k_d;
      w_q    <= w_d;
      prev_q <= prev_d;
    end
  end

endmodule

/* hw/rtl/readout_gray_decode_hit_counter.sv */
// Charge words, total reads, clears and idle words go through accept, then the
// registered memory read and write back in S_RD.
// A BCID word that closes a column walks the configured channel range through
// the totals memory one channel a cycle, after the read of the column bitmap; a
// word closing two columns walks the range once for each column.
// Reset is asynchronous; totals and bitmaps read as zero through valid bits,
// so no clearing pass follows reset.
module readout_gray_decode_hit_counter #(
  parameter int unsigned MaxColumns  = rghc_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned Channels    = rghc_pkg::CHANNELS_DEF,
  parameter int unsigned ColumnWords = rghc_pkg::COLUMN_WORDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rghc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rghc_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      func_i,
  input  logic [rghc_pkg::RAW_W-1:0]      raw_word_i,
  input  logic                            start_req_i,
  input  logic [rghc_pkg::SCA_W-1:0]      sca_count_i,
  input  logic [rghc_pkg::CHAN_W-1:0]     channel_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rghc_pkg::DEC_W-1:0]      decoded_word_o,
  output logic [rghc_pkg::TOTAL_W-1:0]    hit_total_o,
  output logic [rghc_pkg::TOTAL_W-1:0]    clean_total_o
);
  import rghc_pkg::*;

  localparam int unsigned BA = (MaxColumns > 1) ? $clog2(MaxColumns) : 1;
  localparam int unsigned TA = (Channels > 1) ? $clog2(Channels) : 1;
  localparam logic [TOTAL_W-1:0] TOT_MAX = '1;

  // configuration
  logic [CHAN_W-1:0] first_q, last_q;
  logic [GAP_W-1:0]  gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      last_q  <= CHAN_W'(63);
      gap_q   <= GAP_W'(5);
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_FIRST_CH: first_q <= cfg_wdata_i[CHAN_W-1:0];
        REG_LAST_CH:  last_q  <= cfg_wdata_i[CHAN_W-1:0];
        REG_GAP:      gap_q   <= cfg_wdata_i[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc, word_acc;

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign word_acc   = in_acc && (func_e'(func_i) == FUNC_WORD);

  // position tracking and word classification
  logic [DEC_W-1:0] dec;
  op_t              op;

  rghc_pos #(
    .MaxColumns (MaxColumns),
    .Channels   (Channels),
    .ColumnWords(ColumnWords)
  ) u_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .word_acc_i (word_acc),
    .raw_word_i (raw_word_i),
    .start_req_i(start_req_i),
    .sca_count_i(sca_count_i),
    .gap_i      (gap_q),
    .dec_o      (dec),
    .op_o       (op)
  );

  // memories
  logic                  bmp_we;
  logic [BA-1:0]         bmp_waddr, bmp_raddr;
  logic [Channels-1:0]   bmp_wdata, bmp_rdata;
  logic                  tot_we;
  logic [TA-1:0]         tot_waddr, tot_raddr;
  logic [2*TOTAL_W-1:0]  tot_wdata, tot_rdata;

  rghc_ram #(.Width(Channels), .Depth(MaxColumns)) u_bmp_ram (
    .clk_i  (clk_i),
    .we_i   (bmp_we),
    .waddr_i(bmp_waddr),
    .wdata_i(bmp_wdata),
    .raddr_i(bmp_raddr),
    .rdata_o(bmp_rdata)
  );

  rghc_ram #(.Width(2 * TOTAL_W), .Depth(Channels)) u_tot_ram (
    .clk_i  (clk_i),
    .we_i   (tot_we),
    .waddr_i(tot_waddr),
    .wdata_i(tot_wdata),
    .raddr_i(tot_raddr),
    .rdata_o(tot_rdata)
  );

  // item context
  func_e             func_q, func_d;
  logic [DEC_W-1:0]  dec_q, dec_d;
  op_t               op_q, op_d;
  logic              chan_ok_q, chan_ok_d;
  logic [TA-1:0]     chan_q, chan_d;
  logic              closing_q, closing_d;
  logic              clean_q, clean_d;
  logic              cb_q, cb_d;
  logic [COL_W-1:0]  rd_col_q, rd_col_d;
  logic [Channels-1:0] bits_q, bits_d;
  logic [CHAN_W-1:0] ch_q, ch_d;
  logic [MaxColumns-1:0] bmp_vld_q, bmp_vld_d;
  logic [Channels-1:0]   tot_vld_q, tot_vld_d;

  // totals pipeline: read issued last cycle, write back now
  logic              pend_q, pend_d;
  logic [TA-1:0]     pend_ch_q, pend_ch_d;
  logic              pend_clean_q, pend_clean_d;

  logic [DEC_W-1:0]   out_dec_q, out_dec_d;
  logic [TOTAL_W-1:0] out_hit_q, out_hit_d;
  logic [TOTAL_W-1:0] out_cln_q, out_cln_d;

  logic [CHAN_W-1:0]   end_ch;
  logic                range_empty;
  logic [Channels-1:0] bit_mask;
  logic [Channels-1:0] bmp_old;
  logic [TOTAL_W-1:0]  old_hit, old_cln;
  logic [COL_W-1:0]    acc_col;

  assign end_ch = (7'(last_q) < 7'(Channels)) ? last_q : CHAN_W'(Channels - 1);
  assign range_empty = first_q > end_ch;

  always_comb begin
    bit_mask = '0;
    bit_mask[op_q.bit_idx[TA-1:0]] = 1'b1;
  end

  assign bmp_old = bmp_vld_q[rd_col_q[BA-1:0]] ? bmp_rdata : '0;
  assign old_hit = tot_vld_q[pend_ch_q] ? tot_rdata[2*TOTAL_W-1:TOTAL_W] : '0;
  assign old_cln = tot_vld_q[pend_ch_q] ? tot_rdata[TOTAL_W-1:0] : '0;
  assign acc_col = op.charge_hit ? op.bmp_col : (op.close_a ? op.col_a : '0);

  // read addresses
  assign bmp_raddr = (state_q == S_IDLE) ? acc_col[BA-1:0] : '0;
  assign tot_raddr = (state_q == S_IDLE) ? channel_i[TA-1:0] : ch_q[TA-1:0];

  // totals write back, saturating
  always_comb begin
    tot_we    = pend_q;
    tot_waddr = pend_ch_q;
    tot_wdata = {(old_hit != TOT_MAX) ? old_hit + TOTAL_W'(1) : old_hit,
                 (pend_clean_q && (old_cln != TOT_MAX)) ? old_cln + TOTAL_W'(1) : old_cln};
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    dec_d        = dec_q;
    op_d         = op_q;
    chan_ok_d    = chan_ok_q;
    chan_d       = chan_q;
    closing_d    = closing_q;
    clean_d      = clean_q;
    cb_d         = cb_q;
    rd_col_d     = rd_col_q;
    bits_d       = bits_q;
    ch_d         = ch_q;
    bmp_vld_d    = bmp_vld_q;
    tot_vld_d    = tot_vld_q;
    pend_d       = 1'b0;
    pend_ch_d    = pend_ch_q;
    pend_clean_d = pend_clean_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_dec_d    = out_dec_q;
    out_hit_d    = out_hit_q;
    out_cln_d    = out_cln_q;
    bmp_we       = 1'b0;
    bmp_waddr    = rd_col_q[BA-1:0];
    bmp_wdata    = bmp_old | bit_mask;

    if (tot_we) begin
      tot_vld_d[pend_ch_q] = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          func_d    = func_e'(func_i);
          dec_d     = dec;
          op_d      = op;
          chan_ok_d = 7'(channel_i) < 7'(Channels);
          chan_d    = channel_i[TA-1:0];
          rd_col_d  = acc_col;
          closing_d = 1'b0;
          cb_d      = 1'b0;
          clean_d   = 1'b1;
          case (func_e'(func_i))
            FUNC_WORD: begin
              if (start_req_i) begin
                bmp_vld_d = '0;
              end
              if (!op.charge_hit && (op.close_a || op.close_b)) begin
                closing_d = 1'b1;
                clean_d   = op.close_a ? op.clean_a : 1'b1;
                cb_d      = op.close_a && op.close_b;
              end
            end
            FUNC_CLEAR: tot_vld_d = '0;
            default: ;
          endcase
          state_d = S_RD;
        end
      end

      S_RD: begin
        if (closing_q) begin
          bits_d  = bmp_old;
          ch_d    = first_q;
          state_d = range_empty ? S_DRAIN : S_WALK;
        end else begin
          if (func_q == FUNC_WORD && op_q.charge_hit) begin
            bmp_we = 1'b1;
            bmp_vld_d[rd_col_q[BA-1:0]] = 1'b1;
          end
          out_valid_d = 1'b1;
          out_dec_d   = (func_q == FUNC_WORD) ? dec_q : '0;
          out_hit_d   = '0;
          out_cln_d   = '0;
          if (func_q == FUNC_READ && chan_ok_q && tot_vld_q[chan_q]) begin
            out_hit_d = tot_rdata[2*TOTAL_W-1:TOTAL_W];
            out_cln_d = tot_rdata[TOTAL_W-1:0];
          end
          state_d = S_IDLE;
        end
      end

      S_WALK: begin
        pend_d       = bits_q[ch_q[TA-1:0]];
        pend_ch_d    = ch_q[TA-1:0];
        pend_clean_d = clean_q;
        if (ch_q == end_ch) begin
          state_d = S_DRAIN;
        end else begin
          ch_d = ch_q + CHAN_W'(1);
        end
      end

      S_DRAIN: begin
        if (cb_q) begin
          // second column to close is column zero, read at address zero
          cb_d     = 1'b0;
          clean_d  = 1'b1;
          rd_col_d = '0;
          state_d  = S_RD;
        end else begin
          out_valid_d = 1'b1;
          out_dec_d   = dec_q;
          out_hit_d   = '0;
          out_cln_d   = '0;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      closing_q   <= 1'b0;
      cb_q        <= 1'b0;
      bmp_vld_q   <= '0;
      tot_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      closing_q   <= closing_d;
      cb_q        <= cb_d;
      bmp_vld_q   <= bmp_vld_d;
      tot_vld_q   <= tot_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    dec_q        <= dec_d;
    op_q         <= op_d;
    chan_ok_q    <= chan_ok_d;
    chan_q       <= chan_d;
    clean_q      <= clean_d;
    rd_col_q     <= rd_col_d;
    bits_q       <= bits_d;
    ch_q         <= ch_d;
    pend_ch_q    <= pend_ch_d;
    pend_clean_q <= pend_clean_d;
    out_dec_q    <= out_dec_d;
    out_hit_q    <= out_hit_d;
    out_cln_q    <= out_cln_d;
  end

  assign out_valid_o    = out_valid_q;
  assign decoded_word_o = out_dec_q;
  assign hit_total_o    = out_hit_q;
  assign clean_total_o  = out_cln_q;

endmodule

/* test/tb_readout_gray_decode_hit_counter.sv */
`timescale 1ns / 100ps

module tb_readout_gray_decode_hit_counter;
  import rghc_pkg::*;

  localparam int MAX_COLS     = MAX_COLUMNS_DEF;
  localparam int CHANS        = CHANNELS_DEF;
  localparam int COL_WORDS    = COLUMN_WORDS_DEF;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_WORDS  = 100;
  localparam int NUM_SETTINGS = 7;

  typedef struct packed {
    logic [DEC_W-1:0]   dec;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] cleans;
  } word_result_t;

  typedef struct packed {
    func_e              f;
    logic [RAW_W-1:0]   raw;
    logic               start;
    logic [SCA_W-1:0]   sca;
    logic [CHAN_W-1:0]  ch;
    logic               typed;
    word_result_t       want;
  } probe_row_t;

  // Single words: funcs, decode extremes, start handling, column clamp
  localparam probe_row_t PROBES [16] = '{
    '{FUNC_READ,  16'h0000, 1'b0, 5'd0,  6'd0,  1'b1, '0},
    '{FUNC_READ,  16'hFFFF, 1'b1, 5'd31, 6'd63, 1'b1, '0},
    '{FUNC_NOP,   16'hFFFF, 1'b1, 5'd31, 6'd63, 1'b1, '0},
    '{FUNC_CLEAR, 16'hFFFF, 1'b1, 5'd31, 6'd63, 1'b1, '0},
    '{FUNC_WORD,  16'h0000, 1'b1, 5'd0,  6'd0,  1'b1, '0},
    '{FUNC_WORD,  16'hFFFF, 1'b0, 5'd0,  6'd63, 1'b1, '{14'h3AAA, 32'd0, 32'd0}},
    '{FUNC_WORD,  16'h0800, 1'b0, 5'd0,  6'd0,  1'b1, '{14'h0FFF, 32'd0, 32'd0}},
    '{FUNC_WORD,  16'hC000, 1'b0, 5'd0,  6'd0,  1'b1, '0},
    '{FUNC_WORD,  16'h3001, 1'b0, 5'd0,  6'd0,  1'b1, '{14'h3001, 32'd0, 32'd0}},
    '{FUNC_WORD,  16'h0003, 1'b0, 5'd0,  6'd0,  1'b1, '{14'h0002, 32'd0, 32'd0}},
    '{FUNC_WORD,  16'h1000, 1'b1, 5'd31, 6'd0,  1'b1, '{14'h1000, 32'd0, 32'd0}},
    '{FUNC_WORD,  16'h1555, 1'b1, 5'd16, 6'd21, 1'b0, '0},
    '{FUNC_WORD,  16'h9A5C, 1'b0, 5'd1,  6'd42, 1'b0, '0},
    '{FUNC_READ,  16'h0000, 1'b1, 5'd1,  6'd63, 1'b1, '0},
    '{FUNC_READ,  16'h5A5A, 1'b0, 5'd16, 6'd32, 1'b1, '0},
    '{FUNC_NOP,   16'h0000, 1'b0, 5'd0,  6'd0,  1'b1, '0}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           func_i;
  logic [RAW_W-1:0]     raw_word_i;
  logic                 start_req_i;
  logic [SCA_W-1:0]     sca_count_i;
  logic [CHAN_W-1:0]    channel_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [DEC_W-1:0]     decoded_word_o;
  logic [TOTAL_W-1:0]   hit_total_o;
  logic [TOTAL_W-1:0]   clean_total_o;

  readout_gray_decode_hit_counter u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .raw_word_i     (raw_word_i),
    .start_req_i    (start_req_i),
    .sca_count_i    (sca_count_i),
    .channel_i      (channel_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .decoded_word_o (decoded_word_o),
    .hit_total_o    (hit_total_o),
    .clean_total_o  (clean_total_o)
  );

  // Predictor state
  logic [CHANS-1:0]   hit_map [MAX_COLS];
  logic [TOTAL_W-1:0] hit_count [CHANS];
  logic [TOTAL_W-1:0] clean_count [CHANS];
  int word_pos, prev_bcid;
  int first_ch, last_ch, retrig_gap;

  word_result_t word_results_due [$];
  int errors, words_sent, acquisitions, closes, reads;
  bit no_idle, hold_req;

  // Gray to binary, top bit down
  function automatic logic [DEC_W-1:0] gray_to_bin(logic [RAW_W-1:0] raw);
    logic [GRAY_W-1:0] b;
    b[GRAY_W-1] = raw[GRAY_W-1];
    for (int i = GRAY_W - 2; i >= 0; i--) b[i] = b[i+1] ^ raw[i];
    return {raw[DEC_W-1:GRAY_W], b};
  endfunction

  // Add a column's hits in the channel window to the totals
  function automatic void close_col(int col, bit clean);
    if (col >= MAX_COLS) return;
    closes++;
    for (int c = first_ch; c <= last_ch && c < CHANS; c++) begin
      if (hit_map[col][c]) begin
        if (hit_count[c] != '1) hit_count[c]++;
        if (clean && clean_count[c] != '1) clean_count[c]++;
      end
    end
  endfunction

  function automatic word_result_t decode_and_count(func_e f, logic [RAW_W-1:0] raw,
                                                    logic start, logic [SCA_W-1:0] sca,
                                                    logic [CHAN_W-1:0] ch);
    word_result_t r;
    int n, charge_end, total_end, p, col, w, j;
    r = '0;
    case (f)
      FUNC_WORD: begin
        r.dec = gray_to_bin(raw);
        if (start) begin
          foreach (hit_map[i]) hit_map[i] = '0;
          prev_bcid = 0;
          word_pos = 0;
        end
        n = (int'(sca) > MAX_COLS) ? MAX_COLS : int'(sca);
        charge_end = n * COL_WORDS;
        total_end = charge_end + n;
        p = word_pos;
        if (p < charge_end) begin
          col = n - 1 - p / COL_WORDS;
          w = p % COL_WORDS;
          if (w < CHANS && r.dec[HIT_BIT]) hit_map[col][CHANS-1-w] = 1'b1;
        end else if (p < total_end) begin
          // BCID word: closes the column after it, column zero closes itself
          j = p - charge_end;
          col = n - 1 - j;
          if (j > 0) close_col(col + 1, (prev_bcid - int'(r.dec)) >= retrig_gap);
          if (col == 0) close_col(0, 1'b1);
          prev_bcid = int'(r.dec);
        end
        if (p < total_end) word_pos = p + 1;
      end
      FUNC_READ: begin
        r.hits = hit_count[ch];
        r.cleans = clean_count[ch];
      end
      FUNC_CLEAR: begin
        foreach (hit_count[i]) begin
          hit_count[i] = '0;
          clean_count[i] = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one word, log its expectation, wait for the handshake
  task automatic send_word(func_e f, logic [RAW_W-1:0] raw, logic start,
                           logic [SCA_W-1:0] sca, logic [CHAN_W-1:0] ch,
                           logic typed, word_result_t want);
    word_result_t predicted;
    while (!no_idle && $urandom_range(0, 99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    predicted = decode_and_count(f, raw, start, sca, ch);
    word_results_due.push_back(typed ? want : predicted);
    words_sent++;
    if (f == FUNC_READ) reads++;
    in_valid_i  <= 1'b1;
    func_i      <= f;
    raw_word_i  <= raw;
    start_req_i <= start;
    sca_count_i <= sca;
    channel_i   <= ch;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // One acquisition: charge words, BCIDs near the gap, a few extra words;
  // optionally cut short. Reads, no-ops and rare clears are mixed in.
  task automatic run_acquisition(int cols, logic [SCA_W-1:0] sca_val, logic cut);
    int charge_words, total, stop, bcid, k;
    logic [DEC_W-1:0] b14;
    logic [RAW_W-1:0] raw;
    logic [SCA_W-1:0] sca;
    charge_words = cols * COL_WORDS;
    total = charge_words + cols;
    stop = cut ? $urandom_range(1, total - 1) : total + $urandom_range(0, 2);
    bcid = $urandom_range(0, 16383);
    acquisitions++;
    for (int p = 0; p < stop; p++) begin
      k = $urandom_range(0, 399);
      if (k < 16)
        send_word(FUNC_READ, 16'($urandom), 1'($urandom), 5'($urandom), 6'($urandom),
                  1'b0, '0);
      else if (k < 20)
        send_word(FUNC_NOP, 16'($urandom), 1'($urandom), 5'($urandom), 6'($urandom),
                  1'b0, '0);
      else if (k == 20)
        send_word(FUNC_CLEAR, 16'($urandom), 1'($urandom), 5'($urandom), 6'($urandom),
                  1'b0, '0);
      if (p >= charge_words && p < total) begin
        if (p > charge_words) begin
          if ($urandom_range(0, 3) == 0) bcid = $urandom_range(0, 16383);
          else bcid = (bcid - retrig_gap - $urandom_range(0, 6) + 3) & 'h3FFF;
        end
        b14 = 14'(bcid);
        raw = {2'($urandom), b14[DEC_W-1:GRAY_W],
               b14[GRAY_W-1:0] ^ (b14[GRAY_W-1:0] >> 1)};
      end else begin
        raw = 16'($urandom);
      end
      sca = ($urandom_range(0, 199) == 0) ? 5'($urandom) : sca_val;
      send_word(FUNC_WORD, raw, p == 0, sca, 6'($urandom), 1'b0, '0);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(6_000_000);
    $display("[readout_gray_decode_hit_counter] ERROR");
    $finish;
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall_i <= !no_idle && ($urandom_range(0, 99) < 22);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    word_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (word_results_due.size() == 0) begin
        $display("%0t: unexpected word: dec %h hits %0d clean %0d", $time,
                 decoded_word_o, hit_total_o, clean_total_o);
        errors++;
      end else begin
        want = word_results_due.pop_front();
        if (decoded_word_o !== want.dec) begin
          $display("%0t: decoded_word expected %h got %h", $time, want.dec, decoded_word_o);
          errors++;
        end
        if (hit_total_o !== want.hits) begin
          $display("%0t: hit_total expected %0d got %0d", $time, want.hits, hit_total_o);
          errors++;
        end
        if (clean_total_o !== want.cleans) begin
          $display("%0t: clean_total expected %0d got %0d", $time, want.cleans,
                   clean_total_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int start_words, k, cols;
    logic [CFG_W-1:0] wr_first, wr_last, wr_gap;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_FIRST_CH;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    func_i      = FUNC_NOP;
    raw_word_i  = '0;
    start_req_i = 1'b0;
    sca_count_i = '0;
    channel_i   = '0;
    foreach (hit_map[i]) hit_map[i] = '0;
    foreach (hit_count[i]) begin
      hit_count[i] = '0;
      clean_count[i] = '0;
    end
    word_pos   = 0;
    prev_bcid  = 0;
    first_ch   = 0;
    last_ch    = CHANS - 1;
    retrig_gap = 5;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words
    foreach (PROBES[i])
      send_word(PROBES[i].f, PROBES[i].raw, PROBES[i].start, PROBES[i].sca, PROBES[i].ch,
                PROBES[i].typed, PROBES[i].want);
    in_valid_i <= 1'b0;

    // Random acquisitions under a series of register settings
    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      if (ph > 0) begin
        case (ph)
          1: begin wr_first = 0;  wr_last = 63; wr_gap = 0;     end
          2: begin wr_first = 10; wr_last = 20; wr_gap = 16383; end
          3: begin wr_first = 40; wr_last = 10; wr_gap = 7;     end
          4: begin wr_first = 63; wr_last = 63; wr_gap = 3;     end
          5: begin wr_first = 0;  wr_last = 0;  wr_gap = 14'($urandom); end
          default: begin
            wr_first = 14'($urandom_range(0, 63));
            wr_last  = 14'($urandom_range(0, 63));
            wr_gap   = 14'($urandom_range(0, 12));
          end
        endcase
        // junk above the channel field must be ignored
        wr_first = wr_first | (14'($urandom_range(0, 255)) << 6);
        wr_last  = wr_last | (14'($urandom_range(0, 255)) << 6);
        while (word_results_due.size() != 0) @(posedge clk_i);
        repeat (DRAIN_CYCLES) @(posedge clk_i);
        cfg_we_i    <= 1'b1;
        cfg_idx_i   <= REG_FIRST_CH;
        cfg_wdata_i <= wr_first;
        first_ch = int'(wr_first[CHAN_W-1:0]);
        @(posedge clk_i);
        cfg_idx_i   <= REG_LAST_CH;
        cfg_wdata_i <= wr_last;
        last_ch = int'(wr_last[CHAN_W-1:0]);
        @(posedge clk_i);
        cfg_idx_i   <= REG_GAP;
        cfg_wdata_i <= wr_gap;
        retrig_gap = int'(wr_gap);
        @(posedge clk_i);
        cfg_we_i <= 1'b0;
      end
      // column count above the maximum: the words land in the top column
      if (ph == 1) run_acquisition(1, 5'($urandom_range(16, 31)), 1'b0);
      if (ph == 2) no_idle = 1'b1;
      if (ph == 3) hold_req = 1'b1;
      start_words = words_sent;
      while (words_sent - start_words < PHASE_WORDS) begin
        k = $urandom_range(0, 9);
        cols = (k < 5) ? 1 : (k < 9) ? 2 : 3;
        run_acquisition(cols, 5'(cols), $urandom_range(0, 5) == 0);
      end
      // sample the totals: every fourth channel plus both window edges
      for (int c = ph % 4; c < CHANS; c += 4)
        send_word(FUNC_READ, 16'($urandom), 1'($urandom), 5'($urandom), 6'(c), 1'b0, '0);
      send_word(FUNC_READ, 16'($urandom), 1'($urandom), 5'($urandom), 6'(first_ch),
                1'b0, '0);
      send_word(FUNC_READ, 16'($urandom), 1'($urandom), 5'($urandom), 6'(last_ch),
                1'b0, '0);
      no_idle = 1'b0;
      in_valid_i <= 1'b0;
    end

    while (word_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Ran %0d words: %0d acquisitions, %0d column closes, %0d total reads,",
             words_sent, acquisitions, closes, reads);
    $display("over %0d register settings, %0d mismatches.", NUM_SETTINGS, errors);
    if (errors == 0) begin
      $display("[readout_gray_decode_hit_counter] OK");
    end else begin
      $display("[readout_gray_decode_hit_counter] ERROR");
    end
    $finish;
  end

endmodule
